// ----- src/fsas_pkg.sv -----
// Package for the fixed-size ascending sorter.
// Holds the word type, the link and control structs between cells, and the
// sequencer state type. No dependencies.
package fsas_pkg;

  localparam int unsigned WordWidth = 32;

  typedef logic signed [WordWidth-1:0] word_t;

  // Value handed from one cell to its right-hand neighbor.
  typedef struct packed {
    logic  valid;
    word_t data;
  } link_t;

  // Mode of every cell in the chain for one cycle.
  typedef struct packed {
    logic step;   // compare-and-insert step
    logic shift;  // move stored values one cell to the left
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StLoad,
    StSettle,
    StDrain
  } state_e;

endpackage

// ----- src/fsas_if.sv -----
// Valid/ready channel interfaces for the sorter input and output.
// Depends on fsas_pkg for the word type.
interface fsas_in_if;
  import fsas_pkg::*;

  logic  valid;
  logic  ready;
  word_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface fsas_out_if;
  import fsas_pkg::*;

  logic  valid;
  logic  ready;
  word_t sorted_value;
  logic  last;

  modport source (output valid, output sorted_value, output last, input ready);
  modport sink   (input valid, input sorted_value, input last, output ready);
endinterface

// ----- src/fsas_cell.sv -----
// One cell of the insertion sorting chain: holds one value and hands the
// larger of its value and the arriving value to the right. Uses fsas_pkg.
module fsas_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fsas_pkg::cell_ctrl_t ctrl_i,
  input  fsas_pkg::link_t      link_i,
  output fsas_pkg::link_t      link_o,
  input  fsas_pkg::word_t      right_val_i,
  input  logic                 right_full_i,
  output fsas_pkg::word_t      val_o,
  output logic                 full_o
);
  import fsas_pkg::*;

  word_t val_q, val_d;
  logic  full_q, full_d;
  link_t pass_d;
  logic  pass_valid_q;
  word_t pass_data_q;

  // Insert step keeps the smaller value; drain shift pulls from the right.
  always_comb begin
    val_d        = val_q;
    full_d       = full_q;
    pass_d.valid = 1'b0;
    pass_d.data  = link_i.data;
    if (ctrl_i.shift) begin
      val_d  = right_val_i;
      full_d = right_full_i;
    end else if (ctrl_i.step && link_i.valid) begin
      if (!full_q) begin
        val_d  = link_i.data;
        full_d = 1'b1;
      end else if (link_i.data < val_q) begin
        val_d        = link_i.data;
        pass_d.valid = 1'b1;
        pass_d.data  = val_q;
      end else begin
        pass_d.valid = 1'b1;
        pass_d.data  = link_i.data;
      end
    end
  end

  // Control bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q       <= 1'b0;
      pass_valid_q <= 1'b0;
    end else begin
      full_q       <= full_d;
      pass_valid_q <= pass_d.valid;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    pass_data_q <= pass_d.data;
  end

  assign link_o.valid = pass_valid_q;
  assign link_o.data  = pass_data_q;
  assign val_o        = val_q;
  assign full_o       = full_q;

endmodule

// ----- src/fsas_ctrl.sv -----
// Sequencer of the sorter: load, settle and drain phases with one counter.
// Uses fsas_pkg.
module fsas_ctrl #(
  parameter int unsigned COUNT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  output logic                 in_ready_o,
  output fsas_pkg::cell_ctrl_t cell_ctrl_o,
  output logic                 out_load_o,
  output logic                 out_last_o
);
  import fsas_pkg::*;

  localparam int unsigned CntW = (COUNT > 2) ? $clog2(COUNT) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(COUNT - 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            cnt_last;
  logic            take;
  logic            adv;

  assign cnt_last = (cnt_q == CntLast);
  assign take     = (state_q == StDrain) && (!out_valid_i || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (in_valid_i && cnt_last) state_d = StSettle;
      end
      StSettle: begin
        if (cnt_last) state_d = StDrain;
      end
      StDrain: begin
        if (take && cnt_last) state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o        = 1'b0;
    adv               = 1'b0;
    cell_ctrl_o.step  = 1'b0;
    cell_ctrl_o.shift = 1'b0;
    out_load_o        = 1'b0;
    out_last_o        = 1'b0;
    case (state_q)
      StLoad: begin
        in_ready_o       = 1'b1;
        cell_ctrl_o.step = 1'b1;
        adv              = in_valid_i;
      end
      StSettle: begin
        cell_ctrl_o.step = 1'b1;
        adv              = 1'b1;
      end
      StDrain: begin
        cell_ctrl_o.shift = take;
        out_load_o        = take;
        out_last_o        = take && cnt_last;
        adv               = take;
      end
      default: ;
    endcase
  end

  // Phase counter wraps at the end of each phase.
  always_comb begin
    cnt_d = cnt_q;
    if (adv) cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- src/fixed_size_ascending_sort.sv -----
// Fixed-size ascending sorter: a chain of COUNT insertion cells, a sequencer
// and an output register. Depends on fsas_pkg, fsas_if, fsas_cell, fsas_ctrl.
//
//   channel | direction | payload                 | transaction
//   in_i    | sink      | value (32 bit signed)   | one element of a set
//   out_o   | source    | sorted_value, last      | one sorted element
//
// A set of COUNT values is taken at one value per cycle while the cell chain
// sorts them. Then a settle phase lets the last values travel to their cells,
// and the COUNT sorted values leave at up to one per cycle, smallest first.
// Input is refused during the settle and drain phases. Reset clears the cell
// fill bits, the sequencer and the output valid. A stalled output holds the
// chain in place.
module fixed_size_ascending_sort #(
  parameter int unsigned COUNT = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  fsas_in_if.sink    in_i,
  fsas_out_if.source out_o
);
  import fsas_pkg::*;

  cell_ctrl_t cell_ctrl;
  logic       out_load;
  logic       out_last;
  link_t      link [COUNT];
  word_t      cell_val [COUNT];
  logic       cell_full [COUNT];

  logic  out_valid_q;
  word_t out_data_q;
  logic  out_last_q;

  fsas_ctrl #(
    .COUNT(COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_valid_i (out_valid_q),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .cell_ctrl_o (cell_ctrl),
    .out_load_o  (out_load),
    .out_last_o  (out_last)
  );

  // Accepted input enters the first cell.
  assign link[0].valid = in_i.valid && in_i.ready;
  assign link[0].data  = in_i.value;

  // Chain of cells; the last cell has no right neighbor.
  for (genvar i = 0; i < COUNT; i++) begin : g_cell
    if (i < COUNT - 1) begin : g_mid
      fsas_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cell_ctrl),
        .link_i       (link[i]),
        .link_o       (link[i+1]),
        .right_val_i  (cell_val[i+1]),
        .right_full_i (cell_full[i+1]),
        .val_o        (cell_val[i]),
        .full_o       (cell_full[i])
      );
    end else begin : g_end
      fsas_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cell_ctrl),
        .link_i       (link[i]),
        .link_o       (),
        .right_val_i  ('0),
        .right_full_i (1'b0),
        .val_o        (cell_val[i]),
        .full_o       (cell_full[i])
      );
    end
  end

  // Output register takes the smallest value from the head of the chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= cell_val[0];
      out_last_q <= out_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_data_q;
  assign out_o.last         = out_last_q;

endmodule
